/* design/sps_pkg.sv */
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, codes, reset values and phase tables of the stepper phase
// sequencer.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int POSITION_BITS_DEFAULT = 16;
  localparam int PHASE_TABLE_DEPTH     = 8;
  localparam int PHASE_BITS            = $clog2(PHASE_TABLE_DEPTH);

  localparam int ACTION_BITS  = 3;
  localparam int TARGET_BITS  = 16;
  localparam int COIL_BITS    = 4;
  localparam int OUT_POS_BITS = 16;
  localparam int STATUS_BITS  = 2;
  localparam int TICK_BITS    = 16;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int S_TDATA_BITS = 24;
  localparam int M_TDATA_BITS = 24;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_TICK   = 3'd0,
    ACT_MOVE   = 3'd1,
    ACT_RUN    = 3'd2,
    ACT_STOP   = 3'd3,
    ACT_SINGLE = 3'd4,
    ACT_ASSIGN = 3'd5
  } action_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK     = 2'd0,
    ST_BUSY   = 2'd1,
    ST_LIMITS = 2'd2
  } status_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_HALF_STEP = 3'd0,
    CFG_TICKS     = 3'd1,
    CFG_POS_MIN   = 3'd2,
    CFG_POS_MAX   = 3'd3,
    CFG_INVERT    = 3'd4
  } cfg_index_t;

  localparam logic [TICK_BITS-1:0]          TICKS_RESET   = 16'd1;
  localparam logic signed [TARGET_BITS-1:0] POS_MIN_RESET = 16'sd0;
  localparam logic signed [TARGET_BITS-1:0] POS_MAX_RESET = 16'sd100;

  function automatic logic [COIL_BITS-1:0] phase_coils(input logic half,
                                                       input logic [PHASE_BITS-1:0] idx);
    logic [COIL_BITS-1:0] c;
    if (half) begin
      case (idx)
        3'd0: c = 4'b1010;
        3'd1: c = 4'b0010;
        3'd2: c = 4'b0110;
        3'd3: c = 4'b0100;
        3'd4: c = 4'b0101;
        3'd5: c = 4'b0001;
        3'd6: c = 4'b1001;
        3'd7: c = 4'b1000;
        default: c = 4'b0000;
      endcase
    end else begin
      case (idx[1:0])
        2'd0: c = 4'b1010;
        2'd1: c = 4'b0110;
        2'd2: c = 4'b0101;
        2'd3: c = 4'b1001;
        default: c = 4'b0000;
      endcase
    end
    return c;
  endfunction

endpackage

/* design/stepper_phase_sequencer.sv */
// ----------------------------------------------------------------------------
// stepper_phase_sequencer
// Two-phase stepper motor sequencer driving a 4-bit coil pattern from a
// full-step or half-step phase table, with move, free run, step, stop and
// position assign commands.
// ----------------------------------------------------------------------------
// Every input transaction (a command or a tick) produces exactly one result
// transaction, registered as it is accepted. One is accepted per clock, since
// the whole state update is a single register load from short logic, and a
// new transaction is accepted whenever the result register is empty or is
// being taken in the same cycle. Configuration writes take effect at once.
module stepper_phase_sequencer #(
  parameter int POSITION_BITS = sps_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // target[15:0], direction[16], zero fill [23:17]
  input  logic [sps_pkg::S_TDATA_BITS-1:0]     s_tdata,
  // action[2:0]
  input  logic [sps_pkg::ACTION_BITS-1:0]      s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // coils[3:0], position[19:4], running[20], stepped[21], status[23:22]
  output logic [sps_pkg::M_TDATA_BITS-1:0]     m_tdata,
  input  logic                                 cfg_we,
  input  logic [sps_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [sps_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int PB = sps_pkg::PHASE_BITS;

  logic                                 half_step_mode;
  logic [sps_pkg::TICK_BITS-1:0]        ticks_per_step;
  logic signed [sps_pkg::TARGET_BITS-1:0] position_min;
  logic signed [sps_pkg::TARGET_BITS-1:0] position_max;
  logic                                 invert_phase_direction;

  logic [PB-1:0]                        phase_index, phase_index_next;
  logic [POSITION_BITS-1:0]             current_position, current_position_next;
  logic [POSITION_BITS-1:0]             goal_position, goal_position_next;
  logic                                 active, active_next;
  logic                                 free_running, free_running_next;
  logic                                 moving_backward, moving_backward_next;
  logic [sps_pkg::TICK_BITS-1:0]        tick_countdown, tick_countdown_next;
  logic [sps_pkg::COIL_BITS-1:0]        coil_pattern, coil_pattern_next;

  logic                                 accept;
  sps_pkg::action_t                     action;
  logic signed [sps_pkg::TARGET_BITS-1:0] target;
  logic                                 direction;
  logic signed [31:0]                   target_wide;
  logic [POSITION_BITS-1:0]             target_pos;
  logic [31:0]                          pos_wide;

  logic                                 step_backward;
  logic [sps_pkg::COIL_BITS-1:0]        step_coils;
  logic [PB-1:0]                        step_phase;
  logic [POSITION_BITS-1:0]             step_pos;
  logic [sps_pkg::TICK_BITS-1:0]        reload;

  logic                                 stepped;
  sps_pkg::status_t                     status;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = !m_tvalid || m_tready;
  assign action    = sps_pkg::action_t'(s_tuser);
  assign target    = s_tdata[sps_pkg::TARGET_BITS-1:0];
  assign direction = s_tdata[sps_pkg::TARGET_BITS];
  assign target_wide = 32'(target);
  assign target_pos  = target_wide[POSITION_BITS-1:0];
  assign reload = (ticks_per_step == '0) ? '0 : ticks_per_step - sps_pkg::TICK_BITS'(1);
  assign step_backward = (action == sps_pkg::ACT_SINGLE) ? direction : moving_backward;

  sps_step #(
    .POSITION_BITS(POSITION_BITS)
  ) u_step (
    .half_step  (half_step_mode),
    .invert     (invert_phase_direction),
    .backward   (step_backward),
    .phase      (phase_index),
    .pos        (current_position),
    .coils      (step_coils),
    .phase_next (step_phase),
    .pos_next   (step_pos)
  );

  always_comb begin
    phase_index_next      = phase_index;
    current_position_next = current_position;
    goal_position_next    = goal_position;
    active_next           = active;
    free_running_next     = free_running;
    moving_backward_next  = moving_backward;
    tick_countdown_next   = tick_countdown;
    coil_pattern_next     = coil_pattern;
    stepped               = 1'b0;
    status                = sps_pkg::ST_OK;
    case (action)
      sps_pkg::ACT_TICK: begin
        if (active) begin
          if (tick_countdown != '0) begin
            tick_countdown_next = tick_countdown - sps_pkg::TICK_BITS'(1);
          end else begin
            coil_pattern_next     = step_coils;
            phase_index_next      = step_phase;
            current_position_next = step_pos;
            stepped               = 1'b1;
            tick_countdown_next   = reload;
            if (!free_running && step_pos == goal_position) begin
              active_next = 1'b0;
            end
          end
        end
      end
      sps_pkg::ACT_MOVE: begin
        if (active) begin
          status = sps_pkg::ST_BUSY;
        end else if (target < position_min || target > position_max) begin
          status = sps_pkg::ST_LIMITS;
        end else begin
          goal_position_next   = target_pos;
          moving_backward_next = $signed(target_pos) < $signed(current_position);
          free_running_next    = 1'b0;
          active_next          = target_pos != current_position;
          tick_countdown_next  = '0;
        end
      end
      sps_pkg::ACT_RUN: begin
        if (active) begin
          status = sps_pkg::ST_BUSY;
        end else begin
          moving_backward_next = direction;
          free_running_next    = 1'b1;
          active_next          = 1'b1;
          tick_countdown_next  = '0;
        end
      end
      sps_pkg::ACT_STOP: begin
        active_next       = 1'b0;
        free_running_next = 1'b0;
        coil_pattern_next = '0;
      end
      sps_pkg::ACT_SINGLE: begin
        if (active) begin
          status = sps_pkg::ST_BUSY;
        end else begin
          moving_backward_next  = direction;
          coil_pattern_next     = step_coils;
          phase_index_next      = step_phase;
          current_position_next = step_pos;
          stepped               = 1'b1;
        end
      end
      sps_pkg::ACT_ASSIGN: begin
        if (active) begin
          status = sps_pkg::ST_BUSY;
        end else begin
          current_position_next = target_pos;
        end
      end
      default: begin
      end
    endcase
  end

  assign pos_wide = 32'(current_position_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      half_step_mode         <= 1'b0;
      ticks_per_step         <= sps_pkg::TICKS_RESET;
      position_min           <= sps_pkg::POS_MIN_RESET;
      position_max           <= sps_pkg::POS_MAX_RESET;
      invert_phase_direction <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        sps_pkg::CFG_HALF_STEP: half_step_mode         <= cfg_data[0];
        sps_pkg::CFG_TICKS:     ticks_per_step         <= cfg_data;
        sps_pkg::CFG_POS_MIN:   position_min           <= cfg_data;
        sps_pkg::CFG_POS_MAX:   position_max           <= cfg_data;
        sps_pkg::CFG_INVERT:    invert_phase_direction <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_index      <= '0;
      current_position <= '0;
      goal_position    <= '0;
      active           <= 1'b0;
      free_running     <= 1'b0;
      moving_backward  <= 1'b0;
      tick_countdown   <= '0;
      coil_pattern     <= '0;
    end else if (accept) begin
      phase_index      <= phase_index_next;
      current_position <= current_position_next;
      goal_position    <= goal_position_next;
      active           <= active_next;
      free_running     <= free_running_next;
      moving_backward  <= moving_backward_next;
      tick_countdown   <= tick_countdown_next;
      coil_pattern     <= coil_pattern_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {status, stepped, active_next, pos_wide[sps_pkg::OUT_POS_BITS-1:0],
                  coil_pattern_next};
    end
  end

endmodule

/* design/sps_step.sv */
// ----------------------------------------------------------------------------
// sps_step
// One motor step: coil pattern from the phase table, next phase index and
// next position.
// ----------------------------------------------------------------------------
module sps_step #(
  parameter int POSITION_BITS = sps_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                            half_step,
  input  logic                            invert,
  input  logic                            backward,
  input  logic [sps_pkg::PHASE_BITS-1:0]  phase,
  input  logic [POSITION_BITS-1:0]        pos,
  output logic [sps_pkg::COIL_BITS-1:0]   coils,
  output logic [sps_pkg::PHASE_BITS-1:0]  phase_next,
  output logic [POSITION_BITS-1:0]        pos_next
);

  localparam logic [sps_pkg::PHASE_BITS-1:0] PHASE_BACK =
    sps_pkg::PHASE_BITS'(sps_pkg::PHASE_TABLE_DEPTH - 1);
  localparam logic [sps_pkg::PHASE_BITS-1:0] PHASE_FWD = sps_pkg::PHASE_BITS'(1);

  always_comb begin
    coils      = sps_pkg::phase_coils(half_step, phase);
    phase_next = phase + ((backward ^ invert) ? PHASE_BACK : PHASE_FWD);
    pos_next   = backward ? pos - POSITION_BITS'(1) : pos + POSITION_BITS'(1);
  end

endmodule

/* verif/stepper_phase_sequencer_test.sv */
// ----------------------------------------------------------------------------
// Stepper phase sequencer testbench
// Drives commands and ticks into the sequencer through the input stream,
// predicts the coil pattern, position, run flag, step flag and status of each
// transaction, and compares every result transaction with the prediction.
// Register settings change between phases while no transaction is outstanding.
// ----------------------------------------------------------------------------
package sps_test_pkg;
  import sps_pkg::*;

  localparam logic [ACTION_BITS-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACTION_BITS-1:0] ACT_SPARE_HI = 3'd7;

  localparam logic [31:0] FULL_PATTERNS = 32'h956A_956A;
  localparam logic [31:0] HALF_PATTERNS = 32'h8915_462A;

  typedef struct {
    logic [COIL_BITS-1:0]          coils;
    logic signed [OUT_POS_BITS-1:0] position;
    logic                          running;
    logic                          stepped;
    logic [STATUS_BITS-1:0]        status;
  } motion_result_t;

  class motor_scoreboard;
    bit                             half_mode;
    bit                             invert_walk;
    logic [TICK_BITS-1:0]           step_ticks;
    logic signed [TARGET_BITS-1:0]  pos_min;
    logic signed [TARGET_BITS-1:0]  pos_max;
    logic [PHASE_BITS-1:0]          phase;
    logic signed [OUT_POS_BITS-1:0] pos;
    logic signed [OUT_POS_BITS-1:0] goal;
    bit                             active;
    bit                             free_run;
    bit                             backward;
    logic [TICK_BITS-1:0]           countdown;
    logic [COIL_BITS-1:0]           coils;
    motion_result_t                 expected_outputs[$];
    int                             errors;
    int                             checked;
    int                             steps;
    int                             commands;

    function new();
      half_mode   = 1'b0;
      invert_walk = 1'b0;
      step_ticks  = TICKS_RESET;
      pos_min     = POS_MIN_RESET;
      pos_max     = POS_MAX_RESET;
      phase       = '0;
      pos         = '0;
      goal        = '0;
      active      = 1'b0;
      free_run    = 1'b0;
      backward    = 1'b0;
      countdown   = '0;
      coils       = '0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] val);
      case (idx)
        CFG_HALF_STEP: half_mode   = val[0];
        CFG_TICKS:     step_ticks  = val;
        CFG_POS_MIN:   pos_min     = val;
        CFG_POS_MAX:   pos_max     = val;
        CFG_INVERT:    invert_walk = val[0];
        default: ;
      endcase
    endfunction

    function void take_step();
      logic [31:0] patterns;
      patterns = half_mode ? HALF_PATTERNS : FULL_PATTERNS;
      coils = patterns[{phase, 2'b00} +: 4];
      if (backward ^ invert_walk) phase = phase - 3'd1;
      else phase = phase + 3'd1;
      pos = backward ? pos - 16'sd1 : pos + 16'sd1;
      steps++;
    endfunction

    function void note_command(logic [ACTION_BITS-1:0] act,
                               logic signed [TARGET_BITS-1:0] tgt, logic dir);
      motion_result_t r;
      status_t        st;
      bit             stp;
      st  = ST_OK;
      stp = 1'b0;
      commands++;
      case (act)
        ACT_TICK: begin
          if (active) begin
            if (countdown != 0) begin
              countdown = countdown - 16'd1;
            end else begin
              take_step();
              stp = 1'b1;
              countdown = (step_ticks == 0) ? 16'd0 : step_ticks - 16'd1;
              if (!free_run && pos == goal) active = 1'b0;
            end
          end
        end
        ACT_MOVE: begin
          if (active) begin
            st = ST_BUSY;
          end else if (tgt < pos_min || tgt > pos_max) begin
            st = ST_LIMITS;
          end else begin
            goal      = tgt;
            backward  = tgt < pos;
            free_run  = 1'b0;
            active    = (goal != pos);
            countdown = '0;
          end
        end
        ACT_RUN: begin
          if (active) begin
            st = ST_BUSY;
          end else begin
            backward  = dir;
            free_run  = 1'b1;
            active    = 1'b1;
            countdown = '0;
          end
        end
        ACT_STOP: begin
          active   = 1'b0;
          free_run = 1'b0;
          coils    = '0;
        end
        ACT_SINGLE: begin
          if (active) begin
            st = ST_BUSY;
          end else begin
            backward = dir;
            take_step();
            stp = 1'b1;
          end
        end
        ACT_ASSIGN: begin
          if (active) st = ST_BUSY;
          else pos = tgt;
        end
        default: ;
      endcase
      r.coils    = coils;
      r.position = pos;
      r.running  = active;
      r.stepped  = stp;
      r.status   = st;
      expected_outputs.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_output(logic [M_TDATA_BITS-1:0] d);
      motion_result_t e;
      checked++;
      if (expected_outputs.size() == 0) begin
        report($sformatf("result %h arrived with no transaction outstanding", d));
      end else begin
        e = expected_outputs.pop_front();
        if (d[3:0] !== e.coils)
          report($sformatf("result %0d coils %h, expected %h", checked, d[3:0], e.coils));
        if (d[19:4] !== e.position)
          report($sformatf("result %0d position %0d, expected %0d", checked,
                           $signed(d[19:4]), e.position));
        if (d[20] !== e.running)
          report($sformatf("result %0d running %b, expected %b", checked, d[20], e.running));
        if (d[21] !== e.stepped)
          report($sformatf("result %0d stepped %b, expected %b", checked, d[21], e.stepped));
        if (d[23:22] !== e.status)
          report($sformatf("result %0d status %0d, expected %0d", checked, d[23:22],
                           e.status));
      end
    endtask

    function int pending();
      return expected_outputs.size();
    endfunction
  endclass
endpackage

module stepper_phase_sequencer_test;
  import sps_pkg::*;
  import sps_test_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 3;
  localparam int SETTING_COUNT  = 6;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [S_TDATA_BITS-1:0]   s_tdata = '0;
  logic [ACTION_BITS-1:0]    s_tuser = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [M_TDATA_BITS-1:0]   m_tdata;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  int send_idle_pct  = 29;
  int recv_stall_pct = 72;
  int quiet_cycles   = 0;

  int set_half[SETTING_COUNT]  = '{0, 1, 0, 1, 1, 0};
  int set_ticks[SETTING_COUNT] = '{1, 0, 3, 65535, 2, 1};
  int set_min[SETTING_COUNT]   = '{0, -50, -32768, -32768, 10, 32767};
  int set_max[SETTING_COUNT]   = '{100, 50, 32767, 32767, -10, 32767};
  int set_inv[SETTING_COUNT]   = '{0, 1, 0, 1, 0, 1};
  int set_items[SETTING_COUNT] = '{130, 130, 130, 30, 110, 110};
  int send_pcts[3]             = '{29, 72, 0};
  int recv_pcts[3]             = '{72, 29, 0};

  motor_scoreboard sb = new();

  stepper_phase_sequencer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_output(m_tdata);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired after %0d cycles without a transaction", quiet_cycles);
        $display("stepper_phase_sequencer test failed");
        $finish;
      end
    end
  end

  task send_command(logic [ACTION_BITS-1:0] act, logic signed [TARGET_BITS-1:0] tgt,
                    logic dir);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {7'd0, dir, tgt};
    do @(posedge clk); while (!s_tready);
    sb.note_command(act, tgt, dir);
  endtask

  task write_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task settle();
    @(negedge clk);
    while (sb.pending() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [TARGET_BITS-1:0] pick_target(int spread);
    int p;
    int lo;
    int hi;
    p  = int'(sb.pos);
    lo = int'(sb.pos_min);
    hi = int'(sb.pos_max);
    if (lo > hi) return TARGET_BITS'($urandom_range(0, 65535));
    if (p - spread > lo) lo = p - spread;
    if (p + spread < hi) hi = p + spread;
    if (lo > hi) begin
      lo = int'(sb.pos_min);
      hi = int'(sb.pos_max);
    end
    return TARGET_BITS'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  task run_random(int n);
    int                            r;
    logic [ACTION_BITS-1:0]        act;
    logic signed [TARGET_BITS-1:0] tgt;
    logic                          dir;
    for (int i = 0; i < n; i++) begin
      r   = $urandom_range(0, 99);
      tgt = TARGET_BITS'($urandom_range(0, 65535));
      dir = ($urandom_range(0, 1) != 0);
      if (r < 50) begin
        act = ACT_TICK;
      end else if (r < 60) begin
        act = ACT_MOVE;
        if ($urandom_range(0, 99) < 80) tgt = pick_target(24);
      end else if (r < 66) begin
        act = ACT_RUN;
      end else if (r < 71) begin
        act = ACT_STOP;
      end else if (r < 81) begin
        act = ACT_SINGLE;
      end else if (r < 91) begin
        act = ACT_ASSIGN;
        if ($urandom_range(0, 99) < 70) tgt = pick_target(200);
      end else if (r < 95) begin
        act = $urandom_range(0, 1) ? ACT_SPARE_LO : ACT_SPARE_HI;
      end else begin
        act = ACT_TICK;
      end
      send_command(act, tgt, dir);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_command(ACT_TICK, 16'sd0, 1'b0);
    send_command(ACT_STOP, 16'sd0, 1'b0);
    send_command(ACT_SPARE_LO, 16'sd0, 1'b0);
    send_command(ACT_SPARE_HI, -16'sd1, 1'b1);
    send_command(ACT_SINGLE, 16'sd0, 1'b0);
    send_command(ACT_SINGLE, 16'sd0, 1'b1);
    send_command(ACT_ASSIGN, 16'sd32767, 1'b0);
    send_command(ACT_SINGLE, 16'sd0, 1'b0);
    send_command(ACT_ASSIGN, -16'sd32768, 1'b0);
    send_command(ACT_SINGLE, 16'sd0, 1'b1);
    send_command(ACT_ASSIGN, 16'sd5, 1'b0);
    send_command(ACT_MOVE, 16'sd5, 1'b0);
    send_command(ACT_MOVE, -16'sd1, 1'b0);
    send_command(ACT_MOVE, 16'sd101, 1'b0);
    send_command(ACT_MOVE, 16'sd7, 1'b0);
    send_command(ACT_MOVE, 16'sd0, 1'b0);
    send_command(ACT_RUN, 16'sd0, 1'b1);
    send_command(ACT_SINGLE, 16'sd0, 1'b0);
    send_command(ACT_ASSIGN, 16'sd50, 1'b0);
    send_command(ACT_TICK, 16'sd0, 1'b0);
    send_command(ACT_TICK, 16'sd0, 1'b0);
    send_command(ACT_MOVE, 16'sd4, 1'b0);
    send_command(ACT_TICK, 16'sd0, 1'b0);
    send_command(ACT_STOP, 16'sd0, 1'b0);
    send_command(ACT_RUN, 16'sd0, 1'b1);
    send_command(ACT_TICK, 16'sd0, 1'b0);
    send_command(ACT_TICK, 16'sd0, 1'b0);
    send_command(ACT_STOP, 16'sd0, 1'b0);
    s_tvalid <= 1'b0;

    for (int m = 0; m < 3; m++) begin
      for (int s = 0; s < SETTING_COUNT; s++) begin
        settle();
        send_idle_pct  = send_pcts[m];
        recv_stall_pct = recv_pcts[m];
        @(posedge clk);
        write_reg(CFG_HALF_STEP, CFG_DATA_BITS'(set_half[s]));
        write_reg(CFG_TICKS, CFG_DATA_BITS'(set_ticks[s]));
        write_reg(CFG_POS_MIN, CFG_DATA_BITS'(set_min[s]));
        write_reg(CFG_POS_MAX, CFG_DATA_BITS'(set_max[s]));
        write_reg(CFG_INVERT, CFG_DATA_BITS'(set_inv[s]));
        cfg_we <= 1'b0;
        run_random(set_items[s]);
        s_tvalid <= 1'b0;
      end
    end

    settle();
    $display("Run covered %0d transactions in, %0d results checked and %0d motor steps,",
             sb.commands, sb.checked, sb.steps);
    $display("across six register settings under three handshake idling patterns.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("stepper_phase_sequencer test passed");
    end else begin
      $display("stepper_phase_sequencer test failed");
    end
    $finish;
  end
endmodule
